// ===== sv/assert_macros.svh =====
// assertion macros shared by the rc channel frame builder
// expects clk and arst_n to be visible where the macros are used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge out of reset
`define RCFB_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define RCFB_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== sv/rcfb_pkg.sv =====
// types and constants for the rc channel frame builder
// no dependencies
`default_nettype none

package rcfb_pkg;

	// input request payload
	typedef struct packed {
		logic               func;
		logic [2:0]         channel_index;
		logic signed [15:0] channel_value;
	} in_item_t;

	// output request payload
	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_last;
	} out_item_t;

	// request function codes
	localparam logic FUNC_STORE = 1'b0;
	localparam logic FUNC_SEND  = 1'b1;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 11;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE_HEADER = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BIND_ENABLE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_TEST  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_VALUE_MIN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_VALUE_MAX   = 3'd4;

	// configuration reset values
	localparam logic [7:0]  MODE_HEADER_RST = 8'd24;
	localparam logic [10:0] VALUE_MIN_RST   = 11'd0;
	localparam logic [10:0] VALUE_MAX_RST   = 11'd1023;

	// commands from controller to datapath
	typedef struct packed {
		logic store_en;
		logic start;
		logic load;
	} dp_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic last_pos;
		logic out_free;
	} dp_sts_t;

endpackage

`default_nettype wire

// ===== sv/rcfb_datapath.sv =====
// datapath: channel store, config registers, byte position counter, output register
// depends on rcfb_pkg
`default_nettype none

module rcfb_datapath #(
	parameter int CHANNELS    = 6,
	parameter int RESOLUTION  = 10,
	parameter int FRAME_BYTES = 14
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire rcfb_pkg::in_item_t                  in_data,
	input  wire logic                                cfg_we,
	input  wire logic [rcfb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [rcfb_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire rcfb_pkg::dp_cmd_t                   cmd,
	output rcfb_pkg::dp_sts_t                        sts,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output rcfb_pkg::out_item_t                      out_data
);
	import rcfb_pkg::*;

	localparam int POS_W = $clog2(FRAME_BYTES);
	localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [10:0] CENTER = 11'(1 << (RESOLUTION - 1));
	localparam logic [7:0]  HMASK  = 8'(((1 << RESOLUTION) - 1) >> 8);
	localparam logic [3:0]  NCH    = 4'(CHANNELS);

	logic [7:0]       mode_q;
	logic             bind_q;
	logic             rtest_q;
	logic [10:0]      vmin_q;
	logic [10:0]      vmax_q;
	logic [10:0]      store_q [CHANNELS];
	logic [POS_W-1:0] pos_q;
	logic             out_valid_q;
	out_item_t        out_q;

	logic signed [15:0] lim_hi;
	logic signed [15:0] lim_lo;
	logic signed [15:0] clip_hi;
	logic signed [15:0] clip;
	logic               idx_ok;
	logic [4:0]         pos5;
	logic [4:0]         rel;
	logic [2:0]         ch;
	logic [10:0]        entry;
	logic [7:0]         byte_d;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_HEADER_RST;
			bind_q  <= 1'b0;
			rtest_q <= 1'b0;
			vmin_q  <= VALUE_MIN_RST;
			vmax_q  <= VALUE_MAX_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MODE_HEADER: mode_q  <= cfg_data[7:0];
				CFG_BIND_ENABLE: bind_q  <= cfg_data[0];
				CFG_RANGE_TEST:  rtest_q <= cfg_data[0];
				CFG_VALUE_MIN:   vmin_q  <= cfg_data;
				CFG_VALUE_MAX:   vmax_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp: limit to maximum first, then raise to minimum
	always_comb begin
		lim_hi  = $signed({5'b0, vmax_q});
		lim_lo  = $signed({5'b0, vmin_q});
		clip_hi = (in_data.channel_value > lim_hi) ? lim_hi : in_data.channel_value;
		clip    = (clip_hi < lim_lo) ? lim_lo : clip_hi;
		idx_ok  = ({1'b0, in_data.channel_index} < NCH);
	end

	// channel store, starts at center value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				store_q[i] <= CENTER;
			end
		end else if (cmd.store_en && idx_ok) begin
			store_q[in_data.channel_index[CH_W-1:0]] <= clip[10:0];
		end
	end

	// frame byte at current position
	always_comb begin
		pos5  = 5'(pos_q);
		rel   = pos5 - 5'd2;
		ch    = rel[3:1];
		entry = '0;
		if ({1'b0, ch} < NCH) begin
			entry = store_q[ch[CH_W-1:0]];
		end
		if (pos5 == 5'd0) begin
			byte_d = {bind_q, mode_q[6], rtest_q, mode_q[4:0]};
		end else if (pos5 == 5'd1) begin
			byte_d = 8'd0;
		end else if ({1'b0, ch} >= NCH) begin
			byte_d = 8'd0;
		end else if (!rel[0]) begin
			byte_d = ({5'b0, entry[10:8]} & HMASK) | ({5'b0, ch} << (RESOLUTION - 8));
		end else begin
			byte_d = entry[7:0];
		end
	end

	// position counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (cmd.start) begin
			pos_q <= '0;
		end else if (cmd.load) begin
			pos_q <= POS_W'(pos_q + 1'b1);
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_q.frame_byte <= byte_d;
			out_q.frame_last <= sts.last_pos;
		end
	end

	assign sts.last_pos = (pos_q == POS_W'(FRAME_BYTES - 1));
	assign sts.out_free = !out_valid_q || !out_stall;
	assign out_valid    = out_valid_q;
	assign out_data     = out_q;

endmodule

`default_nettype wire

// ===== sv/rcfb_ctrl.sv =====
// controller: accepts requests and sequences frame bytes into the output register
// depends on rcfb_pkg
`default_nettype none

module rcfb_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              func,
	output logic                   in_stall,
	input  wire rcfb_pkg::dp_sts_t sts,
	output rcfb_pkg::dp_cmd_t      cmd
);
	import rcfb_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SEND = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	// request handshake and commands
	always_comb begin
		in_stall     = (state_q != ST_IDLE);
		accept       = in_valid && !in_stall;
		cmd.store_en = accept && (func == FUNC_STORE);
		cmd.start    = accept && (func == FUNC_SEND);
		cmd.load     = (state_q == ST_SEND) && sts.out_free;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.start) begin
					state_d = ST_SEND;
				end
			end
			ST_SEND: begin
				if (cmd.load && sts.last_pos) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== sv/rc_channel_frame_builder.sv =====
// store request: taken, no output; send request: FRAME_BYTES bytes, one per cycle unless
// out_stall holds them, from the output register; a taken send moves the controller to
// its send state, which loads the first byte into the output register; a send keeps the
// input stalled, and the next request is taken once the last byte is loaded into that register
// reset: config to defaults, every channel to center scale, output empty, ready for requests
// top level: controller plus datapath, depends on rcfb_pkg and assert_macros.svh
`default_nettype none

module rc_channel_frame_builder #(
	parameter int CHANNELS    = 6,
	parameter int RESOLUTION  = 10,
	parameter int FRAME_BYTES = 14
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire rcfb_pkg::in_item_t              in_data,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output rcfb_pkg::out_item_t                  out_data,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [rcfb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [rcfb_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rcfb_pkg::*;

	`include "assert_macros.svh"

	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;

	// config writes are always taken
	assign cfg_ready = 1'b1;

	rcfb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.func     (in_data.func),
		.in_stall (in_stall),
		.sts      (dp_sts),
		.cmd      (dp_cmd)
	);

	rcfb_datapath #(
		.CHANNELS    (CHANNELS),
		.RESOLUTION  (RESOLUTION),
		.FRAME_BYTES (FRAME_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (dp_cmd),
		.sts       (dp_sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// a waiting byte is never overwritten
	`RCFB_ASSERT_ALWAYS(a_no_overwrite, !(dp_cmd.load && out_valid && out_stall), "byte overwritten")
	// a taken send request blocks further requests
	`RCFB_ASSERT_NEXT(a_send_busy, dp_cmd.start, in_stall, "send did not block input")
	// loading the last byte frees the input side
	`RCFB_ASSERT_NEXT(a_last_idle, dp_cmd.load && dp_sts.last_pos, !in_stall && out_valid && out_data.frame_last, "frame end not reached")

endmodule

`default_nettype wire
